FILE: hw/rtl/urxf_pkg.sv
package urxf_pkg;

    // command codes carried in s_tuser
    localparam logic [1:0] CMD_READ  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_LINE  = 2'd2;
    localparam logic [1:0] CMD_TICK  = 2'd3;

    // register byte offsets
    localparam logic [7:0] OFF_SR  = 8'd0;
    localparam logic [7:0] OFF_DR  = 8'd4;
    localparam logic [7:0] OFF_BRR = 8'd8;
    localparam logic [7:0] OFF_CR1 = 8'd12;
    localparam logic [7:0] OFF_CR2 = 8'd16;
    localparam logic [7:0] OFF_CR3 = 8'd20;

    // status bits
    localparam int BIT_RXNE = 5;
    localparam int BIT_TC   = 6;
    localparam int BIT_TXE  = 7;

    // control 1 bits
    localparam int BIT_RE = 2;
    localparam int BIT_TE = 3;
    localparam int BIT_UE = 13;

    // request from the register logic to the receive queue
    typedef struct packed {
        logic       push;
        logic [7:0] push_byte;
        logic [1:0] pops;
    } urxf_fifo_ctrl_t;

    // oldest two queued bytes
    typedef struct packed {
        logic [7:0] front0;
        logic [7:0] front1;
    } urxf_fifo_head_t;

endpackage

FILE: hw/rtl/urxf_ram.sv
module urxf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr0,
    input  logic [$clog2(DEPTH)-1:0] raddr1,
    output logic [WIDTH-1:0]         rdata0,
    output logic [WIDTH-1:0]         rdata1
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata0 <= mem[raddr0];
        rdata1 <= mem[raddr1];
    end

endmodule

FILE: hw/rtl/urxf_fifo.sv
module urxf_fifo import urxf_pkg::*; #(
    parameter int FIFO_DEPTH = 256
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  urxf_fifo_ctrl_t                   ctrl,
    output logic [$clog2(FIFO_DEPTH+1)-1:0]   fill_count,
    output urxf_fifo_head_t                   head
);

    localparam int AW = $clog2(FIFO_DEPTH);
    localparam int CW = $clog2(FIFO_DEPTH + 1);

    logic [AW-1:0] write_ptr_reg, write_ptr_next;
    logic [AW-1:0] read_ptr_reg, read_ptr_next;
    logic [CW-1:0] fill_count_reg, fill_count_next;
    logic          byp0_reg, byp0_next;
    logic          byp1_reg, byp1_next;
    logic [7:0]    byp_data_reg;
    logic [AW-1:0] raddr1;
    logic [7:0]    q0, q1;

    function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] p);
        if (p == AW'(FIFO_DEPTH - 1)) begin
            return '0;
        end
        return p + 1'b1;
    endfunction

    always_comb begin
        write_ptr_next = ctrl.push ? ring_next(write_ptr_reg) : write_ptr_reg;
        case (ctrl.pops)
            2'd1:    read_ptr_next = ring_next(read_ptr_reg);
            2'd2:    read_ptr_next = ring_next(ring_next(read_ptr_reg));
            default: read_ptr_next = read_ptr_reg;
        endcase
        fill_count_next = fill_count_reg + CW'(ctrl.push) - CW'(ctrl.pops);
        raddr1 = ring_next(read_ptr_next);
        // ram reads return the old word on a same-address write
        byp0_next = ctrl.push && (write_ptr_reg == read_ptr_next);
        byp1_next = ctrl.push && (write_ptr_reg == raddr1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            write_ptr_reg  <= '0;
            read_ptr_reg   <= '0;
            fill_count_reg <= '0;
            byp0_reg       <= 1'b0;
            byp1_reg       <= 1'b0;
        end else begin
            write_ptr_reg  <= write_ptr_next;
            read_ptr_reg   <= read_ptr_next;
            fill_count_reg <= fill_count_next;
            byp0_reg       <= byp0_next;
            byp1_reg       <= byp1_next;
        end
        byp_data_reg <= ctrl.push_byte;
    end

    urxf_ram #(
        .WIDTH (8),
        .DEPTH (FIFO_DEPTH)
    ) u_store (
        .aclk   (aclk),
        .we     (ctrl.push),
        .waddr  (write_ptr_reg),
        .wdata  (ctrl.push_byte),
        .raddr0 (read_ptr_next),
        .raddr1 (raddr1),
        .rdata0 (q0),
        .rdata1 (q1)
    );

    assign fill_count  = fill_count_reg;
    assign head.front0 = byp0_reg ? byp_data_reg : q0;
    assign head.front1 = byp1_reg ? byp_data_reg : q1;

    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.push |-> fill_count_reg != CW'(FIFO_DEPTH))
        else $error("push into a full queue");

    a_no_pop_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        CW'(ctrl.pops) <= fill_count_reg)
        else $error("pop beyond queued bytes");

    a_empty_ptrs: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_count_reg == '0 |-> write_ptr_reg == read_ptr_reg)
        else $error("empty queue with unequal pointers");

    a_push_counts: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.push && ctrl.pops == 2'd0 |=> fill_count_reg == $past(fill_count_reg) + 1'b1)
        else $error("fill count missed a push");

endmodule

FILE: hw/rtl/usart_registers_with_rx_fifo.sv
// channel   | ports               | direction | contents
// ----------+---------------------+-----------+-----------------------------------------
// command   | s_tvalid/s_tready   | in        | bus read/write, line byte or poll tick
// result    | m_tvalid/m_tready   | out       | read data, transmit byte, drop flag
//
// one transaction per cycle is sustained while m_tready is high; a taken command goes
// from the input register through the step logic into the result register; the
// receive queue ram is read ahead from the next read pointer, so its two oldest bytes
// are ready while the command sits in the input register
// reset is synchronous on aresetn low; queue storage is not cleared,
// since only written entries are ever read
// a low m_tready holds the result register; one more command waits in the input
// register, and s_tready drops only when both are occupied
module usart_registers_with_rx_fifo import urxf_pkg::*; #(
    parameter int FIFO_DEPTH = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // reg_offset[7:0], write_data[39:8], line_byte[47:40]
    input  logic [1:0]  s_tuser,   // cmd[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // read_data[31:0], tx_byte[39:32]
    output logic [1:0]  m_tuser    // tx_valid[0], rx_dropped[1]
);

    localparam int CW = $clog2(FIFO_DEPTH + 1);

    // input register
    logic        in_valid_reg;
    logic [1:0]  in_cmd_reg;
    logic [7:0]  in_off_reg;
    logic [31:0] in_wdata_reg;
    logic [7:0]  in_lb_reg;

    // result register
    logic        out_valid_reg, out_valid_next;
    logic [31:0] out_rdata_reg;
    logic        out_txv_reg;
    logic [7:0]  out_txb_reg;
    logic        out_drop_reg;

    // register file
    logic [31:0] status_reg, status_next;
    logic [7:0]  data_reg, data_next;
    logic [31:0] baud_reg, baud_next;
    logic [31:0] control1_reg, control1_next;
    logic [31:0] control2_reg, control2_next;
    logic [31:0] control3_reg, control3_next;

    // step results
    logic [31:0] rd;
    logic        txv;
    logic [7:0]  txb;
    logic        drop;

    logic            advance;
    urxf_fifo_ctrl_t fifo_ctrl;
    urxf_fifo_head_t fifo_head;
    logic [CW-1:0]   fifo_fill;

    // the command in the input register moves on when the result register frees up
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_comb begin
        logic en;
        logic have1;
        logic have2;
        logic d1;
        logic d2;
        logic [7:0] data1;

        en    = control1_reg[BIT_UE] && control1_reg[BIT_RE];
        have1 = fifo_fill != '0;
        have2 = fifo_fill > CW'(1);
        d1    = 1'b0;
        d2    = 1'b0;
        data1 = data_reg;

        status_next   = status_reg;
        data_next     = data_reg;
        baud_next     = baud_reg;
        control1_next = control1_reg;
        control2_next = control2_reg;
        control3_next = control3_reg;
        rd            = '0;
        txv           = 1'b0;
        txb           = '0;
        drop          = 1'b0;
        fifo_ctrl.push      = 1'b0;
        fifo_ctrl.push_byte = in_lb_reg;
        fifo_ctrl.pops      = 2'd0;

        if (advance) begin
            case (in_cmd_reg)
                CMD_READ: begin
                    // drain ahead of the read
                    d1 = en && !status_reg[BIT_RXNE] && have1;
                    if (d1) begin
                        data1 = fifo_head.front0;
                        status_next[BIT_RXNE] = 1'b1;
                        data_next = data1;
                    end
                    case (in_off_reg)
                        OFF_SR:  rd = status_next;
                        OFF_DR: begin
                            rd = {24'd0, data1};
                            // taking the data frees rxne, so drain again
                            d2 = en && (d1 ? have2 : have1);
                            status_next[BIT_RXNE] = d2;
                            data_next = d2 ? (d1 ? fifo_head.front1 : fifo_head.front0)
                                           : 8'd0;
                        end
                        OFF_BRR: rd = baud_reg;
                        OFF_CR1: rd = control1_reg;
                        OFF_CR2: rd = control2_reg;
                        OFF_CR3: rd = control3_reg;
                        default: rd = '0;
                    endcase
                    fifo_ctrl.pops = {1'b0, d1} + {1'b0, d2};
                end
                CMD_WRITE: begin
                    case (in_off_reg)
                        OFF_SR:  status_next = in_wdata_reg;
                        OFF_DR: begin
                            data_next = in_wdata_reg[7:0];
                            if (control1_reg[BIT_UE] && control1_reg[BIT_TE]) begin
                                txv = 1'b1;
                                txb = in_wdata_reg[7:0];
                            end
                            status_next[BIT_TXE] = 1'b1;
                            status_next[BIT_TC]  = 1'b1;
                        end
                        OFF_BRR: baud_next = in_wdata_reg;
                        OFF_CR1: begin
                            control1_next = in_wdata_reg;
                            // drain under the new enables
                            d1 = in_wdata_reg[BIT_UE] && in_wdata_reg[BIT_RE]
                                 && !status_reg[BIT_RXNE] && have1;
                            if (d1) begin
                                data_next = fifo_head.front0;
                                status_next[BIT_RXNE] = 1'b1;
                            end
                            fifo_ctrl.pops = {1'b0, d1};
                        end
                        OFF_CR2: control2_next = in_wdata_reg;
                        OFF_CR3: control3_next = in_wdata_reg;
                        default: ;
                    endcase
                end
                CMD_LINE: begin
                    // a full queue drops the byte and keeps its state
                    if (fifo_fill == CW'(FIFO_DEPTH)) begin
                        drop = 1'b1;
                    end else begin
                        fifo_ctrl.push = 1'b1;
                    end
                end
                default: begin
                    // poll tick: drain only
                    d1 = en && !status_reg[BIT_RXNE] && have1;
                    if (d1) begin
                        data_next = fifo_head.front0;
                        status_next[BIT_RXNE] = 1'b1;
                    end
                    fifo_ctrl.pops = {1'b0, d1};
                end
            endcase
        end

        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    urxf_fifo #(
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctrl       (fifo_ctrl),
        .fill_count (fifo_fill),
        .head       (fifo_head)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            status_reg    <= '0;
            data_reg      <= '0;
            baud_reg      <= '0;
            control1_reg  <= '0;
            control2_reg  <= '0;
            control3_reg  <= '0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            out_valid_reg <= out_valid_next;
            status_reg    <= status_next;
            data_reg      <= data_next;
            baud_reg      <= baud_next;
            control1_reg  <= control1_next;
            control2_reg  <= control2_next;
            control3_reg  <= control3_next;
        end
        // payload, no reset
        if (s_tready && s_tvalid) begin
            in_cmd_reg   <= s_tuser;
            in_off_reg   <= s_tdata[7:0];
            in_wdata_reg <= s_tdata[39:8];
            in_lb_reg    <= s_tdata[47:40];
        end
        if (advance) begin
            out_rdata_reg <= rd;
            out_txv_reg   <= txv;
            out_txb_reg   <= txb;
            out_drop_reg  <= drop;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_txb_reg, out_rdata_reg};
    assign m_tuser  = {out_drop_reg, out_txv_reg};

endmodule
